FILE: sv/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FBPE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define FBPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/fbpe_pkg.sv
package fbpe_pkg;

  localparam int BYTE_W  = 8;
  localparam int OUT_W   = 32;
  localparam int WIDTH_W = 4;

  // Result kinds on the output channel.
  localparam logic KIND_WIDTH = 1'b0;
  localparam logic KIND_WORD  = 1'b1;

  // Number of bits moved along the cell chain in one cycle, 0 to 8.
  typedef logic [WIDTH_W-1:0] shift_t;

  // Frame buffer port strobes.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } fb_ctl_t;

  // Bit length of a byte; a zero byte counts as one bit.
  function automatic logic [WIDTH_W-1:0] bit_length(input logic [BYTE_W-1:0] v);
    logic [WIDTH_W-1:0] n;
    n = WIDTH_W'(1);
    for (int k = 1; k < BYTE_W; k++) begin
      if ((v >> k) != '0) begin
        n = WIDTH_W'(k + 1);
      end
    end
    return n;
  endfunction

  // Mask that keeps the low w bits of a byte, w from 1 to 8.
  function automatic logic [BYTE_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    logic [BYTE_W:0] m;
    m = ((BYTE_W+1)'(1) << w) - (BYTE_W+1)'(1);
    return m[BYTE_W-1:0];
  endfunction

endpackage

FILE: sv/fbpe_cell.sv
// One bit of the packing word. Each cycle the bit takes the value found
// shift places further up the chain; the window holds the next eight bits.
module fbpe_cell (
  input  logic                                  clk,
  input  fbpe_pkg::shift_t                      shift_i,
  input  logic [fbpe_pkg::BYTE_W-1:0]           window,
  output logic                                  bit_r
);

  logic       bit_nxt;
  logic [2:0] sel;

  always_comb begin
    sel = 3'(shift_i - fbpe_pkg::shift_t'(1));
    if (shift_i == '0) begin
      bit_nxt = bit_r;
    end else begin
      bit_nxt = window[sel];
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

endmodule

FILE: sv/fbpe_frame_buf.sv
// Byte store for the open frame: one write port, one registered read port.
module fbpe_frame_buf #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic                          clk,
  input  fbpe_pkg::fb_ctl_t             ctl,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [fbpe_pkg::BYTE_W-1:0]   wr_data,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [fbpe_pkg::BYTE_W-1:0]   rd_data_r
);

  logic [fbpe_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/frame_bitpack_encoder.sv
// Frame bit-packing encoder. Bytes arrive one transaction at a time and are
// stored until a frame of FRAME_LEN bytes is complete or a byte flagged as
// the last of the stream arrives. The block then delivers the frame's bit
// width (1 to 8), followed by every WORD_BITS-bit word that fills up while
// the low width bits of each stored byte are packed, least significant bit
// first. The packing word carries over from one frame to the next; at the end
// of the stream a partly filled word is delivered with zero fill. run_last
// marks the final result of each closing byte and stream_end the final result
// of the stream. Timing: while a frame is being collected a byte is accepted
// every cycle. Once it closes, the input is held off while the frame is
// walked again: each stored byte is read from the registered buffer port and
// shifted into the cells; the bits of a byte that straddles a word boundary
// are held back and shifted in once the full word has been delivered. A word
// that the last byte of the frame completes is delivered before the closing
// result. At the end of a stream the cells are fed zero bits, up to eight at a
// time, until the word is full and can be delivered; when no bits are left
// over, the block goes straight to the closing result. The walk waits while
// the output holds off a waiting result. A frame must be stored whole in the
// single frame buffer before its width is known, and is then read back once
// to pack it. A full word waits in the row of cells while the output cannot
// take it. There is no clearing pass after reset.
`include "assert_macros.svh"

module frame_bitpack_encoder #(
  parameter int FRAME_LEN = 128,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [31:0] out_value,
  output logic        out_run_last,
  output logic        out_stream_end
);

  localparam int ADDR_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam int CNT_W  = $clog2(FRAME_LEN + 1);
  localparam int ACC_W  = $clog2(WORD_BITS + 1);
  localparam int BW     = fbpe_pkg::BYTE_W;
  localparam int WW     = fbpe_pkg::WIDTH_W;

  // Sequencer states: collecting bytes, packing the frame, zero-filling the
  // final word of a stream, and delivering the closing result.
  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_PACK    = 2'd1;
  localparam logic [1:0] ST_FLUSH   = 2'd2;
  localparam logic [1:0] ST_CLOSE   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [WW-1:0]       width_r, width_nxt;
  logic                last_r, last_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                rd_valid_r, rd_valid_nxt;
  logic [BW-1:0]       pend_r, pend_nxt;
  logic [WW-1:0]       pend_cnt_r, pend_cnt_nxt;
  logic [ACC_W-1:0]    acc_bits_r, acc_bits_nxt;

  // A result is held back one place so that its closing flags are known
  // before it reaches the output register.
  logic                hold_valid_r, hold_valid_nxt;
  logic                hold_kind_r, hold_kind_nxt;
  logic [31:0]         hold_value_r, hold_value_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_item_kind_r, out_item_kind_nxt;
  logic [31:0]         out_value_r, out_value_nxt;
  logic                out_run_last_r, out_run_last_nxt;
  logic                out_stream_end_r, out_stream_end_nxt;

  logic [BW-1:0]           rd_data;
  fbpe_pkg::fb_ctl_t       fb_ctl;
  logic [WORD_BITS-1:0]    cell_bits;
  logic [WORD_BITS+BW-1:0] chain_ext;

  logic                in_take;
  logic                frame_close;
  logic [WW-1:0]       byte_len;
  logic                out_free;
  logic                acc_full;
  logic                packing;
  logic                push;
  logic                blocked;
  logic [ACC_W-1:0]    acc_eff;
  logic [ACC_W-1:0]    room;
  logic                use_pend;
  logic [BW-1:0]       src_bits;
  logic [WW-1:0]       src_cnt;
  fbpe_pkg::shift_t    shift;
  logic                consume_rd;
  logic                rd_issue;
  logic                pack_done;

  assign in_stall    = (state_r != ST_COLLECT);
  assign in_take     = in_valid && !in_stall;
  assign byte_len    = fbpe_pkg::bit_length(in_byte_value);
  assign frame_close = in_last_byte || (fill_r == CNT_W'(FRAME_LEN - 1));

  assign out_free = !out_valid_r || !out_stall;
  assign acc_full = (acc_bits_r == ACC_W'(WORD_BITS));
  assign packing  = (state_r == ST_PACK) || (state_r == ST_FLUSH);
  assign push     = packing && acc_full && out_free;
  assign blocked  = acc_full && !out_free;
  assign acc_eff  = push ? '0 : acc_bits_r;
  assign room     = ACC_W'(WORD_BITS) - acc_eff;
  assign use_pend = (pend_cnt_r != '0);

  // Bits offered to the top of the cell chain this cycle.
  always_comb begin
    if (state_r == ST_FLUSH) begin
      src_bits = '0;
      src_cnt  = (acc_eff != '0) ? WW'(BW) : '0;
    end else if (state_r != ST_PACK) begin
      src_bits = '0;
      src_cnt  = '0;
    end else if (use_pend) begin
      src_bits = pend_r;
      src_cnt  = pend_cnt_r;
    end else begin
      src_bits = rd_data & fbpe_pkg::width_mask(width_r);
      src_cnt  = rd_valid_r ? width_r : '0;
    end
  end

  always_comb begin
    if (blocked) begin
      shift = '0;
    end else if (ACC_W'(src_cnt) <= room) begin
      shift = src_cnt;
    end else begin
      shift = room[WW-1:0];
    end
  end

  assign consume_rd = (state_r == ST_PACK) && !use_pend && rd_valid_r && !blocked;
  assign rd_issue   = (state_r == ST_PACK) && (rd_idx_r != fill_r) &&
                      (!rd_valid_r || consume_rd);
  assign pack_done  = (rd_idx_r == fill_r) && !rd_valid_r && !use_pend && !acc_full;

  assign fb_ctl.wr_en = in_take;
  assign fb_ctl.rd_en = rd_issue;

  fbpe_frame_buf #(
    .DEPTH  (FRAME_LEN),
    .ADDR_W (ADDR_W)
  ) u_frame_buf (
    .clk       (clk),
    .ctl       (fb_ctl),
    .wr_addr   (fill_r[ADDR_W-1:0]),
    .wr_data   (in_byte_value),
    .rd_addr   (rd_idx_r[ADDR_W-1:0]),
    .rd_data_r (rd_data)
  );

  // The packing word is a row of bit cells. New bits enter above the top
  // cell and everything moves down by the shift amount, so once WORD_BITS
  // bits have entered, the first of them sits in the bottom cell.
  assign chain_ext = {src_bits, cell_bits};

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    fbpe_cell u_cell (
      .clk     (clk),
      .shift_i (shift),
      .window  (chain_ext[i+BW:i+1]),
      .bit_r   (cell_bits[i])
    );
  end

  always_comb begin
    state_nxt          = state_r;
    fill_nxt           = fill_r;
    width_nxt          = width_r;
    last_nxt           = last_r;
    rd_idx_nxt         = rd_idx_r;
    rd_valid_nxt       = rd_valid_r;
    pend_nxt           = pend_r;
    pend_cnt_nxt       = pend_cnt_r;
    acc_bits_nxt       = acc_bits_r;
    hold_valid_nxt     = hold_valid_r;
    hold_kind_nxt      = hold_kind_r;
    hold_value_nxt     = hold_value_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_item_kind_nxt  = out_item_kind_r;
    out_value_nxt      = out_value_r;
    out_run_last_nxt   = out_run_last_r;
    out_stream_end_nxt = out_stream_end_r;

    // A full word pushes the held result out and takes its place.
    if (push) begin
      out_valid_nxt      = 1'b1;
      out_item_kind_nxt  = hold_kind_r;
      out_value_nxt      = hold_value_r;
      out_run_last_nxt   = 1'b0;
      out_stream_end_nxt = 1'b0;
      hold_kind_nxt      = fbpe_pkg::KIND_WORD;
      hold_value_nxt     = 32'(cell_bits);
    end

    if (packing && !blocked) begin
      acc_bits_nxt = acc_eff + ACC_W'(shift);
    end

    if ((state_r == ST_PACK) && !blocked && (use_pend || rd_valid_r)) begin
      pend_nxt     = src_bits >> shift;
      pend_cnt_nxt = src_cnt - shift;
    end

    if (rd_issue) begin
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
    end
    rd_valid_nxt = rd_issue || (rd_valid_r && !consume_rd);

    case (state_r)
      ST_COLLECT: begin
        if (in_take) begin
          fill_nxt  = fill_r + CNT_W'(1);
          width_nxt = (byte_len > width_r) ? byte_len : width_r;
          if (frame_close) begin
            last_nxt       = in_last_byte;
            hold_valid_nxt = 1'b1;
            hold_kind_nxt  = fbpe_pkg::KIND_WIDTH;
            hold_value_nxt = 32'(width_nxt);
            state_nxt      = ST_PACK;
          end
        end
      end
      ST_PACK: begin
        if (pack_done) begin
          state_nxt = last_r ? ST_FLUSH : ST_CLOSE;
        end
      end
      ST_FLUSH: begin
        if (!acc_full && (acc_bits_r == '0)) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_item_kind_nxt  = hold_kind_r;
          out_value_nxt      = hold_value_r;
          out_run_last_nxt   = 1'b1;
          out_stream_end_nxt = last_r;
          hold_valid_nxt     = 1'b0;
          fill_nxt           = '0;
          width_nxt          = '0;
          rd_idx_nxt         = '0;
          last_nxt           = 1'b0;
          state_nxt          = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_COLLECT;
      fill_r       <= '0;
      width_r      <= '0;
      last_r       <= 1'b0;
      rd_idx_r     <= '0;
      rd_valid_r   <= 1'b0;
      pend_cnt_r   <= '0;
      acc_bits_r   <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      width_r      <= width_nxt;
      last_r       <= last_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_valid_r   <= rd_valid_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      acc_bits_r   <= acc_bits_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r           <= pend_nxt;
    hold_kind_r      <= hold_kind_nxt;
    hold_value_r     <= hold_value_nxt;
    out_item_kind_r  <= out_item_kind_nxt;
    out_value_r      <= out_value_nxt;
    out_run_last_r   <= out_run_last_nxt;
    out_stream_end_r <= out_stream_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_item_kind  = out_item_kind_r;
  assign out_value      = out_value_r;
  assign out_run_last   = out_run_last_r;
  assign out_stream_end = out_stream_end_r;

  // While bytes are being collected no result of the previous frame remains.
  `FBPE_ASSERT(a_collect_hold_empty, clk, rst_n,
               (state_r != ST_COLLECT) || !hold_valid_r, "result held while collecting")
  // The packing word never counts more bits than it holds.
  `FBPE_ASSERT(a_acc_bound, clk, rst_n, acc_bits_r <= ACC_W'(WORD_BITS),
               "packing word overfilled")
  // The read pointer never runs past the stored bytes.
  `FBPE_ASSERT(a_rd_bound, clk, rst_n, rd_idx_r <= fill_r, "frame read beyond fill")
  // A pushed word takes the held place.
  `FBPE_ASSERT_NEXT(a_push_hold, clk, rst_n, push,
                    hold_valid_r && (hold_kind_r == fbpe_pkg::KIND_WORD), "pushed word not held")
  // Closing delivers a result marked as the last of its byte.
  `FBPE_ASSERT_NEXT(a_close_flag, clk, rst_n, (state_r == ST_CLOSE) && out_free,
                    out_valid_r && out_run_last_r, "closing result not flagged")

endmodule
